[src/assert_macros.svh]
// Assertion macros used by the port-level checker of this project.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that is also checked while reset is held.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/lmfw_pkg.sv]
// Types, codes and constants of the LED matrix frame writer.
// No dependencies; used by every module of the block but lmfw_ram.
package lmfw_pkg;

  localparam int ROW_W  = 3;
  localparam int COL_W  = 3;
  localparam int OP_W   = 2;
  localparam int DIM_W  = 4;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 8;

  // Command codes.
  localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
  localparam logic [OP_W-1:0] OP_PIXEL = 2'd1;
  localparam logic [OP_W-1:0] OP_RECT  = 2'd2;

  localparam logic [1:0] LAST_CTRL = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CTRL,
    ST_ROWS,
    ST_TAIL
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             pixel_value;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } reg_word_t;

  // The four display control words sent ahead of the blank rows on init.
  function automatic reg_word_t ctrl_word(input logic [1:0] idx);
    reg_word_t w;
    case (idx)
      2'd0:    w = '{addr: 4'h9, data: 8'h00};
      2'd1:    w = '{addr: 4'hA, data: 8'h0F};
      2'd2:    w = '{addr: 4'hB, data: 8'h07};
      default: w = '{addr: 4'hC, data: 8'h01};
    endcase
    return w;
  endfunction

endpackage

[src/lmfw_ram.sv]
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module lmfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

[src/lmfw_row_upd.sv]
// Computes the new bitmap of one frame row for a pixel or rectangle command.
// Depends on lmfw_pkg.
module lmfw_row_upd (
  input  lmfw_pkg::cmd_t                  cmd,
  input  logic [lmfw_pkg::ROW_W-1:0]      row_idx,
  input  logic [lmfw_pkg::DATA_W-1:0]     old_byte,
  output logic [lmfw_pkg::DATA_W-1:0]     new_byte
);
  import lmfw_pkg::*;

  logic [4:0]        bot;
  logic [4:0]        right;
  logic [4:0]        r5;
  logic              rect_on;
  logic              in_rows;
  logic              horiz;
  logic [DATA_W-1:0] span;
  logic [DATA_W-1:0] col_bit;
  logic [DATA_W-1:0] right_bit;
  logic [DATA_W-1:0] rect_mask;

  // Bottom row and right column may run past the grid; five bits hold them.
  assign r5      = 5'(row_idx);
  assign bot     = 5'(cmd.row) + 5'(cmd.height) - 5'd1;
  assign right   = 5'(cmd.col) + 5'(cmd.width) - 5'd1;
  assign rect_on = (cmd.width != '0) && (cmd.height != '0);
  assign in_rows = (r5 >= 5'(cmd.row)) && (r5 <= bot);
  assign horiz   = (row_idx == cmd.row) || (r5 == bot);

  assign col_bit   = 8'h80 >> cmd.col;
  assign right_bit = (right < 5'd8) ? (8'h80 >> right[2:0]) : '0;

  // Column c sits at bit 7-c; the span is clipped at the right edge.
  always_comb begin
    for (int c = 0; c < DATA_W; c++) begin
      span[DATA_W-1-c] = (5'(c) >= 5'(cmd.col)) && (5'(c) <= right);
    end
  end

  always_comb begin
    rect_mask = '0;
    if (rect_on && horiz) begin
      rect_mask = rect_mask | span;
    end
    if (rect_on && in_rows) begin
      rect_mask = rect_mask | col_bit | right_bit;
    end
  end

  always_comb begin
    case (cmd.op)
      OP_PIXEL: begin
        if (row_idx != cmd.row) begin
          new_byte = old_byte;
        end else if (cmd.pixel_value) begin
          new_byte = old_byte | col_bit;
        end else begin
          new_byte = old_byte & ~col_bit;
        end
      end
      OP_RECT: begin
        new_byte = old_byte | rect_mask;
      end
      default: begin
        new_byte = '0;
      end
    endcase
  end

endmodule

[src/led_matrix_frame_writer.sv]
// Top level of the LED matrix frame writer: command sequencer and frame store.
// Depends on lmfw_pkg, lmfw_ram and lmfw_row_upd.
//
//  Channel | Ports                                              | Beat taken when
//  --------+----------------------------------------------------+-------------------------
//  input   | in_operation in_row in_col in_pixel_value          | start high, busy low
//          | in_width in_height                                 |
//  result  | out_reg_address out_reg_data out_last              | out_valid high (1 cycle)
//
// An init command puts out four control words and one blank word per row, one
// beat per cycle. A pixel or rectangle command reads each row from the frame
// memory, merges it and writes it back in the next cycle; as that memory's read
// port is registered, the final row is written back in the tail state ST_TAIL.
// A command with the unused operation code is taken and dropped without leaving idle.
// Reset is synchronous: the frame reads as all zero through per-row valid bits.
// The receiver cannot stall; each beat is shown for exactly one cycle, and a new
// command may be taken while the final beat of the previous one is on the ports.
module led_matrix_frame_writer #(
  parameter int NUM_ROWS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [lmfw_pkg::OP_W-1:0]       in_operation,
  input  logic [lmfw_pkg::ROW_W-1:0]      in_row,
  input  logic [lmfw_pkg::COL_W-1:0]      in_col,
  input  logic                            in_pixel_value,
  input  logic [lmfw_pkg::DIM_W-1:0]      in_width,
  input  logic [lmfw_pkg::DIM_W-1:0]      in_height,
  output logic                            out_valid,
  output logic [lmfw_pkg::ADDR_W-1:0]     out_reg_address,
  output logic [lmfw_pkg::DATA_W-1:0]     out_reg_data,
  output logic                            out_last
);
  import lmfw_pkg::*;

  localparam int ROW_AW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(NUM_ROWS - 1);

  state_t             state_r, state_nxt;
  cmd_t               cmd_r;
  logic [1:0]         ctrl_idx_r;
  logic [ROW_AW-1:0]  row_cnt_r;
  logic               rd_pend_r;
  logic [ROW_AW-1:0]  rd_row_r;
  logic               rd_vld_r;
  logic [NUM_ROWS-1:0] vld_r;

  logic               accept;
  logic               row_last;
  logic               is_init;
  logic               ram_re;
  logic               ld_ctrl;
  logic               ld_blank;
  logic [DATA_W-1:0]  ram_rdata;
  logic [DATA_W-1:0]  old_byte;
  logic [DATA_W-1:0]  new_byte;
  reg_word_t          cw;

  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [DATA_W-1:0]  out_data_r;
  logic               out_last_r;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign row_last = (row_cnt_r == LAST_ROW);
  assign is_init  = (cmd_r.op == OP_INIT);
  assign cw       = ctrl_word(ctrl_idx_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_operation)
            OP_INIT:  state_nxt = ST_CTRL;
            OP_PIXEL: state_nxt = ST_ROWS;
            OP_RECT:  state_nxt = ST_ROWS;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CTRL: begin
        if (ctrl_idx_r == LAST_CTRL) begin
          state_nxt = ST_ROWS;
        end
      end
      ST_ROWS: begin
        if (row_last) begin
          state_nxt = is_init ? ST_IDLE : ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs. Init rows are blank, so they bypass the frame memory.
  always_comb begin
    ram_re   = 1'b0;
    ld_ctrl  = 1'b0;
    ld_blank = 1'b0;
    case (state_r)
      ST_CTRL: begin
        ld_ctrl = 1'b1;
      end
      ST_ROWS: begin
        ram_re   = !is_init;
        ld_blank = is_init;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ctrl_idx_r <= '0;
      row_cnt_r  <= '0;
      rd_pend_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= ram_re;
      if (accept) begin
        ctrl_idx_r <= '0;
        row_cnt_r  <= '0;
      end else begin
        if (state_r == ST_CTRL) begin
          ctrl_idx_r <= ctrl_idx_r + 2'd1;
        end
        if (state_r == ST_ROWS) begin
          row_cnt_r <= row_cnt_r + ROW_AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= '{op: in_operation, row: in_row, col: in_col,
                 pixel_value: in_pixel_value, width: in_width, height: in_height};
    end
  end

  // A row never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (rd_pend_r) begin
      vld_r[rd_row_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_row_r <= row_cnt_r;
      rd_vld_r <= vld_r[row_cnt_r];
    end
  end

  lmfw_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_ROWS)
  ) u_frame (
    .clk   (clk),
    .we    (rd_pend_r),
    .waddr (rd_row_r),
    .wdata (new_byte),
    .re    (ram_re),
    .raddr (row_cnt_r),
    .rdata (ram_rdata)
  );

  assign old_byte = rd_vld_r ? ram_rdata : '0;

  lmfw_row_upd u_row_upd (
    .cmd      (cmd_r),
    .row_idx  (ROW_W'(rd_row_r)),
    .old_byte (old_byte),
    .new_byte (new_byte)
  );

  // Output register: one beat per cycle from exactly one of three sources.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ld_ctrl || ld_blank || rd_pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_ctrl) begin
      out_addr_r <= cw.addr;
      out_data_r <= cw.data;
      out_last_r <= 1'b0;
    end else if (ld_blank) begin
      out_addr_r <= ADDR_W'(row_cnt_r) + ADDR_W'(1);
      out_data_r <= '0;
      out_last_r <= row_last;
    end else if (rd_pend_r) begin
      out_addr_r <= ADDR_W'(rd_row_r) + ADDR_W'(1);
      out_data_r <= new_byte;
      out_last_r <= (rd_row_r == LAST_ROW);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reg_address = out_addr_r;
  assign out_reg_data    = out_data_r;
  assign out_last        = out_last_r;

endmodule

[src/lmfw_chk.sv]
// Port-level checker for the LED matrix frame writer, bound to the top level.
// Depends on assert_macros.svh and lmfw_pkg.
`include "assert_macros.svh"

module lmfw_chk #(
  parameter int NUM_ROWS = 8
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [lmfw_pkg::OP_W-1:0]   in_operation,
  input logic                        out_valid,
  input logic [lmfw_pkg::ADDR_W-1:0] out_reg_address,
  input logic                        out_last
);
  import lmfw_pkg::*;

  `ASSERT_CLK(a_last_is_final_row, out_valid && out_last |-> out_reg_address == ADDR_W'(NUM_ROWS), "last beat is not the final row")
  `ASSERT_CLK(a_burst_contiguous, out_valid && !out_last |=> out_valid, "gap inside a burst")
  `ASSERT_CLK(a_cmd_goes_busy, start && !busy && (in_operation == OP_INIT || in_operation == OP_PIXEL || in_operation == OP_RECT) |=> busy, "command taken without going busy")
  `ASSERT_CLK(a_addr_range, out_valid |-> out_reg_address != '0 && out_reg_address <= 4'd12, "register address out of range")
  `ASSERT_CLK_RST(a_reset_quiet, !rst_n |=> !out_valid, "beat right after reset")

endmodule

bind led_matrix_frame_writer lmfw_chk #(.NUM_ROWS(NUM_ROWS)) u_lmfw_chk (.*);

[sim/lmfw_burst_checker.sv]
// Scoreboard for the LED matrix frame writer: predicts the register word burst of each
// accepted command from a private frame copy and compares every result beat in order.
// Depends on lmfw_pkg for the command codes and field widths.
module lmfw_burst_checker #(
  parameter int NUM_ROWS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [lmfw_pkg::OP_W-1:0]   in_operation,
  input  logic [lmfw_pkg::ROW_W-1:0]  in_row,
  input  logic [lmfw_pkg::COL_W-1:0]  in_col,
  input  logic                        in_pixel_value,
  input  logic [lmfw_pkg::DIM_W-1:0]  in_width,
  input  logic [lmfw_pkg::DIM_W-1:0]  in_height,
  input  logic                        out_valid,
  input  logic [lmfw_pkg::ADDR_W-1:0] out_reg_address,
  input  logic [lmfw_pkg::DATA_W-1:0] out_reg_data,
  input  logic                        out_last,
  output int                          cmds_taken,
  output int                          words_pending,
  output int                          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import lmfw_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              last;
  } disp_word_t;

  logic [7:0] frame_copy [NUM_ROWS];
  disp_word_t expected_words [$];

  initial begin
    cmds_taken = 0;
    words_pending = 0;
    fail_count = 0;
  end

  // Pixels outside the grid are silently dropped.
  function automatic void plot_pixel(input int r, input int c, input logic on);
    if (r < NUM_ROWS && c < 8) begin
      frame_copy[r][7 - c] = on;
    end
  endfunction

  function automatic void queue_rows(input logic blank);
    disp_word_t w;
    for (int r = 0; r < NUM_ROWS; r++) begin
      w.addr = ADDR_W'(r + 1);
      w.data = blank ? '0 : frame_copy[r];
      w.last = (r == NUM_ROWS - 1);
      expected_words.push_back(w);
    end
  endfunction

  function automatic void queue_ctrl(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    disp_word_t w;
    w.addr = a;
    w.data = d;
    w.last = 1'b0;
    expected_words.push_back(w);
  endfunction

  function automatic void predict_burst();
    int r0;
    int c0;
    int w;
    int h;
    r0 = in_row;
    c0 = in_col;
    w = in_width;
    h = in_height;
    case (in_operation)
      OP_INIT: begin
        queue_ctrl(4'h9, 8'h00);
        queue_ctrl(4'hA, 8'h0F);
        queue_ctrl(4'hB, 8'h07);
        queue_ctrl(4'hC, 8'h01);
        queue_rows(1'b1);
      end
      OP_PIXEL: begin
        plot_pixel(r0, c0, in_pixel_value);
        queue_rows(1'b0);
      end
      OP_RECT: begin
        if (w != 0 && h != 0) begin
          for (int i = 0; i < w; i++) begin
            plot_pixel(r0, c0 + i, 1'b1);
            plot_pixel(r0 + h - 1, c0 + i, 1'b1);
          end
          for (int i = 0; i < h; i++) begin
            plot_pixel(r0 + i, c0, 1'b1);
            plot_pixel(r0 + i, c0 + w - 1, 1'b1);
          end
        end
        queue_rows(1'b0);
      end
      default: begin
        // The spare code is taken and produces nothing.
      end
    endcase
  endfunction

  function automatic void report_failure(input string what);
    if (fail_count < 10) begin
      $display("%0t: %s", $realtime, what);
    end
    fail_count++;
  endfunction

  always @(posedge clk) begin
    disp_word_t want;
    if (!rst_n) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        frame_copy[r] = '0;
      end
      expected_words.delete();
    end else begin
      // Compare the beat on the ports first; a command taken in the same cycle
      // only appends behind it.
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          report_failure($sformatf("unexpected word addr=%h data=%h last=%b",
                                   out_reg_address, out_reg_data, out_last));
        end else begin
          want = expected_words.pop_front();
          if (out_reg_address !== want.addr || out_reg_data !== want.data ||
              out_last !== want.last) begin
            report_failure($sformatf("word mismatch: expected addr=%h data=%h last=%b, got addr=%h data=%h last=%b",
                                     want.addr, want.data, want.last,
                                     out_reg_address, out_reg_data, out_last));
          end
        end
      end
      if (start && !busy) begin
        predict_burst();
        cmds_taken++;
      end
    end
    words_pending = expected_words.size();
  end

endmodule

[sim/led_matrix_frame_writer_tb.sv]
// Top of the LED matrix frame writer testbench: clock, reset, command stimulus and verdict.
// Depends on lmfw_pkg, the led_matrix_frame_writer RTL and lmfw_burst_checker.
module led_matrix_frame_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmfw_pkg::*;

  localparam int GRID_ROWS = 8;
  // The fourth operation code has no name in the package; the block drops it.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int RANDOM_CMDS = 225;
  // In the final stretch of random commands the sender never pauses.
  localparam int CALM_TAIL = 40;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     in_operation;
  logic [ROW_W-1:0]    in_row;
  logic [COL_W-1:0]    in_col;
  logic                in_pixel_value;
  logic [DIM_W-1:0]    in_width;
  logic [DIM_W-1:0]    in_height;
  logic                out_valid;
  logic [ADDR_W-1:0]   out_reg_address;
  logic [DATA_W-1:0]   out_reg_data;
  logic                out_last;

  int cmds_taken;
  int words_pending;
  int fail_count;
  int drawn_cmds;

  led_matrix_frame_writer #(
    .NUM_ROWS(GRID_ROWS)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_pixel_value  (in_pixel_value),
    .in_width        (in_width),
    .in_height       (in_height),
    .out_valid       (out_valid),
    .out_reg_address (out_reg_address),
    .out_reg_data    (out_reg_data),
    .out_last        (out_last)
  );

  // The checker sits beside the block, watching both channels. It predicts every
  // burst and hands back how many commands were taken, how many words are still
  // owed, and how many failures it has seen.
  lmfw_burst_checker #(
    .NUM_ROWS(GRID_ROWS)
  ) scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_pixel_value  (in_pixel_value),
    .in_width        (in_width),
    .in_height       (in_height),
    .out_valid       (out_valid),
    .out_reg_address (out_reg_address),
    .out_reg_data    (out_reg_data),
    .out_last        (out_last),
    .cmds_taken      (cmds_taken),
    .words_pending   (words_pending),
    .fail_count      (fail_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Offers one command beat starting at this falling edge and returns at the
  // falling edge right after the block takes it. Start is left high, so a
  // following command can be offered back to back without a gap.
  task automatic offer_cmd(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] r,
                           input logic [COL_W-1:0] c, input logic pv,
                           input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    int taken_so_far;
    taken_so_far = cmds_taken;
    in_operation = op;
    in_row = r;
    in_col = c;
    in_pixel_value = pv;
    in_width = w;
    in_height = h;
    start = 1'b1;
    do @(negedge clk); while (cmds_taken == taken_so_far);
  endtask

  // Holds the input side quiet for a number of cycles.
  task automatic pause_sender(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Holds the input side quiet until every predicted word has come out.
  task automatic drain_results();
    start = 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  // Rectangle sizes stay mostly on the grid, but sometimes run well past it so
  // that the upper bit of the size fields is exercised too.
  function automatic logic [DIM_W-1:0] pick_dim();
    if ($urandom_range(0, 99) < 85) begin
      return DIM_W'($urandom_range(0, 8));
    end
    return DIM_W'($urandom_range(9, 15));
  endfunction

  initial begin
    int pick;
    start = 1'b0;
    in_operation = OP_INIT;
    in_row = '0;
    in_col = '0;
    in_pixel_value = 1'b0;
    in_width = '0;
    in_height = '0;
    drawn_cmds = 0;
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part. Init first, then single pixels at the four corners, a
    // clear of a lit pixel and a clear of a dark one.
    offer_cmd(OP_INIT, 3'd0, 3'd0, 1'b0, 4'd0, 4'd0);
    offer_cmd(OP_PIXEL, 3'd0, 3'd0, 1'b1, 4'd0, 4'd0);
    offer_cmd(OP_PIXEL, 3'd7, 3'd7, 1'b1, 4'd0, 4'd0);
    offer_cmd(OP_PIXEL, 3'd0, 3'd7, 1'b1, 4'd15, 4'd15);
    offer_cmd(OP_PIXEL, 3'd7, 3'd0, 1'b1, 4'd0, 4'd0);
    offer_cmd(OP_PIXEL, 3'd0, 3'd0, 1'b0, 4'd0, 4'd0);
    offer_cmd(OP_PIXEL, 3'd4, 3'd3, 1'b0, 4'd0, 4'd0);
    // Init leaves the frame as it was; the rows after it still show the pixels.
    offer_cmd(OP_INIT, 3'd7, 3'd7, 1'b1, 4'd15, 4'd15);
    offer_cmd(OP_PIXEL, 3'd1, 3'd1, 1'b0, 4'd0, 4'd0);
    // Rectangles: full frame, zero width, zero height, zero width and height.
    offer_cmd(OP_RECT, 3'd0, 3'd0, 1'b0, 4'd8, 4'd8);
    offer_cmd(OP_RECT, 3'd2, 3'd2, 1'b0, 4'd0, 4'd5);
    offer_cmd(OP_RECT, 3'd2, 3'd2, 1'b0, 4'd5, 4'd0);
    offer_cmd(OP_RECT, 3'd0, 3'd0, 1'b0, 4'd0, 4'd0);
    pause_sender(3);
    // Wipe the frame pixel by pixel is too long; clear one and draw small shapes: a single pixel and thin lines.
    offer_cmd(OP_PIXEL, 3'd3, 3'd3, 1'b0, 4'd0, 4'd0);
    offer_cmd(OP_RECT, 3'd3, 3'd3, 1'b1, 4'd1, 4'd1);
    offer_cmd(OP_RECT, 3'd5, 3'd1, 1'b0, 4'd6, 4'd1);
    offer_cmd(OP_RECT, 3'd1, 3'd6, 1'b0, 4'd1, 4'd6);
    // Outlines that run off the right and bottom edges: the off-grid pixels
    // are dropped while the rest are drawn.
    offer_cmd(OP_RECT, 3'd6, 3'd5, 1'b0, 4'd8, 4'd8);
    offer_cmd(OP_RECT, 3'd7, 3'd7, 1'b0, 4'd15, 4'd15);
    offer_cmd(OP_RECT, 3'd2, 3'd4, 1'b0, 4'd15, 4'd3);
    // The spare code is swallowed without output, twice, each time back to back
    // with a real command on each side.
    offer_cmd(OP_SPARE, 3'd5, 3'd5, 1'b1, 4'd3, 4'd3);
    offer_cmd(OP_PIXEL, 3'd6, 3'd2, 1'b1, 4'd0, 4'd0);
    offer_cmd(OP_SPARE, 3'd0, 3'd0, 1'b0, 4'd0, 4'd0);
    offer_cmd(OP_INIT, 3'd0, 3'd0, 1'b0, 4'd0, 4'd0);

    // Let the pipeline run completely dry before the random part.
    drain_results();

    // Random part. Spare-code commands are noise and do not count.
    while (drawn_cmds < RANDOM_CMDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        offer_cmd(OP_INIT, ROW_W'($urandom), COL_W'($urandom), 1'($urandom),
                  DIM_W'($urandom), DIM_W'($urandom));
        drawn_cmds++;
      end else if (pick < 50) begin
        offer_cmd(OP_PIXEL, ROW_W'($urandom_range(0, 7)), COL_W'($urandom_range(0, 7)),
                  1'($urandom), DIM_W'($urandom), DIM_W'($urandom));
        drawn_cmds++;
      end else if (pick < 92) begin
        offer_cmd(OP_RECT, ROW_W'($urandom_range(0, 7)), COL_W'($urandom_range(0, 7)),
                  1'($urandom), pick_dim(), pick_dim());
        drawn_cmds++;
      end else begin
        offer_cmd(OP_SPARE, ROW_W'($urandom), COL_W'($urandom), 1'($urandom),
                  DIM_W'($urandom), DIM_W'($urandom));
      end

      // Random bursts of sender idling, so gaps land on every phase of a
      // burst; an occasional full drain; none at all in the closing stretch.
      if (drawn_cmds < RANDOM_CMDS - CALM_TAIL) begin
        if ($urandom_range(0, 39) == 0) begin
          drain_results();
        end else if ($urandom_range(0, 3) == 0) begin
          pause_sender($urandom_range(1, 19));
        end
      end
    end

    start = 1'b0;
    while (words_pending != 0) @(negedge clk);
    // Wait on to catch any stray beat after the last expected one.
    repeat (20) @(negedge clk);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: a correct run ends in well under a tenth of this time.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
